@@ rtl/sdq_pkg.sv @@
// Shared types and constants for the sortable deque.
// No dependencies; imported by the interfaces and by the controller, datapath and top level.
package sdq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;

  // Request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SORT       = 3'd4,
    ACT_CLEAR      = 3'd5,
    ACT_DUMP       = 3'd6
  } action_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic single;      // apply request action, load one result beat
    logic dump_start;  // clear walk position
    logic dump_rd;     // read element at walk position
    logic dump_emit;   // load read element as a result beat, advance
    logic sort_start;  // clear outer position
    logic sort_rdi;    // read element at outer position
    logic sort_ldi;    // hold it, set inner position to outer + 1
    logic sort_rdj;    // read element at inner position
    logic sort_cmp;    // compare, write back the larger, advance inner
    logic sort_wri;    // write held element at outer position, advance outer
    logic sort_done;   // load the closing result beat
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register can take a beat this cycle
    logic fill_lt2;  // fewer than two elements stored
    logic empty;     // no elements stored
    logic k_end;     // walk / outer position is the last element
    logic i_end;     // outer position is the second last element
    logic j_end;     // inner position is the last element
  } status_t;

endpackage

@@ rtl/sdq_req_if.sv @@
// Request channel of the sortable deque: valid/ready plus action and value.
// Depends on sdq_pkg.
interface sdq_req_if;
  import sdq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

@@ rtl/sdq_rsp_if.sv @@
// Result channel of the sortable deque: valid/ready plus the result fields.
// Depends on sdq_pkg.
interface sdq_rsp_if;
  import sdq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  element;
  logic [COUNT_W-1:0]         count;
  logic                       is_empty;
  logic                       error;
  logic                       last;

  modport source (output valid, output element, output count, output is_empty,
                  output error, output last, input ready);
  modport sink   (input valid, input element, input count, input is_empty,
                  input error, input last, output ready);
endinterface

@@ rtl/sortable_deque.sv @@
// Top level of the sortable deque: controller plus datapath.
// Depends on sdq_pkg, sdq_req_if, sdq_rsp_if, sdq_ctrl, sdq_dp, sdq_ram.
//
//   channel  dir  handshake    beat contents
//   req      in   valid/ready  action, value
//   rsp      out  valid/ready  element, count, is_empty, error, last
//
// Push, pop, clear, a sort of fewer than two elements and an empty dump load
// their single result beat on acceptance; a new request is taken every cycle
// while rsp is taken. A dump of n elements runs the accepting cycle, then one
// store read and one beat per element, each beat waiting while rsp is stalled.
// After the accepting cycle, a sort of n elements is paced by the single store
// read port: each outer pass reads and holds its element, reads and compares
// each later one, then writes the held element back; a closing beat ends it.
// rst is synchronous; the store holds no reset value. A stalled rsp holds
// its beat and closes req until the beat is taken.
module sortable_deque #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  sdq_req_if.sink   req,
  sdq_rsp_if.source rsp
);
  import sdq_pkg::*;

  cmd_t    cmd;
  status_t status;

  sdq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .cmd        (cmd),
    .status     (status)
  );

  sdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_action (req.action),
    .req_value  (req.value),
    .rsp        (rsp)
  );

endmodule

@@ rtl/sdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sdq_dp.sv @@
// Datapath of the sortable deque: ring pointers, element store, sort and
// dump position counters, and the result register. Depends on sdq_pkg, sdq_ram.
module sdq_dp #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sdq_pkg::cmd_t                cmd,
  output sdq_pkg::status_t             status,
  input  logic [sdq_pkg::ACTION_W-1:0] req_action,
  input  logic [sdq_pkg::VALUE_W-1:0]  req_value,
  sdq_rsp_if.source                    rsp
);
  import sdq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [AW-1:0]      front;
  logic [FW-1:0]      fill;
  logic [FW-1:0]      pos_i;
  logic [FW-1:0]      pos_j;
  logic [VALUE_W-1:0] cur;

  logic [AW-1:0]      front_next;
  logic [FW-1:0]      fill_next;
  logic               err;
  logic               full;
  logic               empty;
  logic [AW-1:0]      front_dec;
  logic [AW-1:0]      front_inc;
  logic               greater;
  logic               out_free;
  action_t            act;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;

  // Ring slot of a position counted from the front
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [FW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, pos[AW-1:0]};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign act       = action_t'(req_action);
  assign full      = (fill == FW'(DEPTH));
  assign empty     = (fill == '0);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign greater   = $signed(cur) > $signed(rdata);
  assign out_free  = !rsp.valid || rsp.ready;

  // Single-beat actions and store write port
  always_comb begin
    front_next = front;
    fill_next  = fill;
    err        = 1'b0;
    we         = 1'b0;
    waddr      = slot(front, pos_i);
    wdata      = cur;
    if (cmd.single) begin
      case (act)
        ACT_PUSH_FRONT: begin
          if (full) begin
            err = 1'b1;
          end else begin
            front_next = front_dec;
            fill_next  = fill + FW'(1);
            we         = 1'b1;
            waddr      = front_dec;
            wdata      = req_value;
          end
        end
        ACT_PUSH_BACK: begin
          if (full) begin
            err = 1'b1;
          end else begin
            fill_next = fill + FW'(1);
            we        = 1'b1;
            waddr     = slot(front, fill);
            wdata     = req_value;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            err = 1'b1;
          end else begin
            front_next = front_inc;
            fill_next  = fill - FW'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            err = 1'b1;
          end else begin
            fill_next = fill - FW'(1);
          end
        end
        ACT_CLEAR: begin
          front_next = '0;
          fill_next  = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.sort_cmp && greater) begin
      we    = 1'b1;
      waddr = slot(front, pos_j);
    end else if (cmd.sort_wri) begin
      we    = 1'b1;
    end
  end

  // Store read port
  assign re    = cmd.dump_rd || cmd.sort_rdi || cmd.sort_rdj;
  assign raddr = cmd.sort_rdj ? slot(front, pos_j) : slot(front, pos_i);

  sdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      fill  <= '0;
    end else begin
      front <= front_next;
      fill  <= fill_next;
    end
  end

  // Walk positions and held sort element
  always_ff @(posedge clk) begin
    if (cmd.dump_start || cmd.sort_start) begin
      pos_i <= '0;
    end else if (cmd.dump_emit || cmd.sort_wri) begin
      pos_i <= pos_i + FW'(1);
    end
    if (cmd.sort_ldi) begin
      pos_j <= pos_i + FW'(1);
    end else if (cmd.sort_cmp) begin
      pos_j <= pos_j + FW'(1);
    end
    if (cmd.sort_ldi || (cmd.sort_cmp && greater)) begin
      cur <= rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.single || cmd.dump_emit || cmd.sort_done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      rsp.element  <= '0;
      rsp.count    <= COUNT_W'(fill_next);
      rsp.is_empty <= (fill_next == '0);
      rsp.error    <= err;
      rsp.last     <= 1'b1;
    end else if (cmd.dump_emit) begin
      rsp.element  <= rdata;
      rsp.count    <= COUNT_W'(fill);
      rsp.is_empty <= empty;
      rsp.error    <= 1'b0;
      rsp.last     <= status.k_end;
    end else if (cmd.sort_done) begin
      rsp.element  <= '0;
      rsp.count    <= COUNT_W'(fill);
      rsp.is_empty <= empty;
      rsp.error    <= 1'b0;
      rsp.last     <= 1'b1;
    end
  end

  // Status back to the controller
  assign status.out_free = out_free;
  assign status.fill_lt2 = (fill < FW'(2));
  assign status.empty    = empty;
  assign status.k_end    = ((pos_i + FW'(1)) == fill);
  assign status.i_end    = ((pos_i + FW'(2)) == fill);
  assign status.j_end    = ((pos_j + FW'(1)) == fill);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("element count beyond store depth");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.single |=> (rsp.valid && rsp.last))
    else $error("single action did not produce a closing beat");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.error) |-> rsp.last)
    else $error("error flagged on a non-closing beat");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.single && err) |=> ($stable(fill) && $stable(front)))
    else $error("rejected push or pop changed the queue");
`endif

endmodule

@@ rtl/sdq_ctrl.sv @@
// Controller of the sortable deque: request acceptance and the sequencing
// of sort and dump walks. Depends on sdq_pkg.
module sdq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic [sdq_pkg::ACTION_W-1:0] req_action,
  output logic                         req_ready,
  output sdq_pkg::cmd_t                cmd,
  input  sdq_pkg::status_t             status
);
  import sdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUMP_RD,
    S_DUMP_EMIT,
    S_SORT_RDI,
    S_SORT_LDI,
    S_SORT_RDJ,
    S_SORT_CMP,
    S_SORT_WRI
  } state_t;

  state_t  state;
  state_t  state_next;
  logic    accept;
  action_t act;

  // Extra state for the closing sort beat, set at the end of S_SORT_WRI and served in S_IDLE
  logic    sort_finish;
  logic    sort_finish_next;

  assign act       = action_t'(req_action);
  assign req_ready = (state == S_IDLE) && !sort_finish && status.out_free;
  assign accept    = req_valid && req_ready;

  // Next state and commands
  always_comb begin
    state_next       = state;
    sort_finish_next = sort_finish;
    cmd              = '0;
    case (state)
      S_IDLE: begin
        if (sort_finish) begin
          if (status.out_free) begin
            cmd.sort_done    = 1'b1;
            sort_finish_next = 1'b0;
          end
        end else if (accept) begin
          case (act)
            ACT_SORT: begin
              if (status.fill_lt2) begin
                cmd.single = 1'b1;
              end else begin
                cmd.sort_start = 1'b1;
                state_next     = S_SORT_RDI;
              end
            end
            ACT_DUMP: begin
              if (status.empty) begin
                cmd.single = 1'b1;
              end else begin
                cmd.dump_start = 1'b1;
                state_next     = S_DUMP_RD;
              end
            end
            default: begin
              cmd.single = 1'b1;
            end
          endcase
        end
      end
      S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_next  = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (status.out_free) begin
          cmd.dump_emit = 1'b1;
          state_next    = status.k_end ? S_IDLE : S_DUMP_RD;
        end
      end
      S_SORT_RDI: begin
        cmd.sort_rdi = 1'b1;
        state_next   = S_SORT_LDI;
      end
      S_SORT_LDI: begin
        cmd.sort_ldi = 1'b1;
        state_next   = S_SORT_RDJ;
      end
      S_SORT_RDJ: begin
        cmd.sort_rdj = 1'b1;
        state_next   = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        cmd.sort_cmp = 1'b1;
        state_next   = status.j_end ? S_SORT_WRI : S_SORT_RDJ;
      end
      S_SORT_WRI: begin
        cmd.sort_wri = 1'b1;
        if (status.i_end) begin
          state_next       = S_IDLE;
          sort_finish_next = 1'b1;
        end else begin
          state_next = S_SORT_RDI;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sort_finish <= 1'b0;
    end else begin
      state       <= state_next;
      sort_finish <= sort_finish_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == S_IDLE))
    else $error("request taken during a walk");

  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    (cmd.sort_start || cmd.dump_start) |=> !req_ready)
    else $error("input open while a walk is running");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.single, cmd.dump_emit, cmd.sort_done}))
    else $error("two result loads in one cycle");
`endif

endmodule

@@ tb/sortable_deque_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sortable_deque: directed and random deque traffic, every result
// beat checked against an in-bench model of the ring store, front pointer and fill count.
// Depends on sdq_pkg, sdq_req_if, sdq_rsp_if and the sortable_deque RTL.
module sortable_deque_test;
  import sdq_pkg::*;

  localparam int DEPTH       = 32;
  localparam int N_RANDOM    = 480;
  localparam int IDLE_PCT    = 24;
  localparam int CYCLE_LIMIT = 4_000_000;

  // One pending request, or a marker that holds the sender until all results are in
  typedef struct {
    action_t                   act;
    logic signed [VALUE_W-1:0] val;
    bit                        pause;
  } deque_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] element;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic                      error;
    logic                      last;
  } deque_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      req_valid  = 1'b0;
  logic [ACTION_W-1:0]       req_action = '0;
  logic signed [VALUE_W-1:0] req_value  = '0;
  logic                      rsp_ready  = 1'b0;

  sdq_req_if req ();
  sdq_rsp_if rsp ();

  assign req.valid  = req_valid;
  assign req.action = req_action;
  assign req.value  = req_value;
  assign rsp.ready  = rsp_ready;

  sortable_deque #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #4 clk = ~clk;

  // Model of the deque contents
  logic signed [VALUE_W-1:0] ring [DEPTH];
  int ring_front = 0;
  int ring_fill  = 0;

  deque_op_t   ops_pending [$];
  deque_beat_t beats_due   [$];
  int n_taken  = 0;
  int n_fail   = 0;
  int n_cycles = 0;

  // Long stretch with no idling on either side
  wire quiet = (n_taken >= 200) && (n_taken < 320);

  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic void expect_beat(logic signed [VALUE_W-1:0] elem, logic err, logic fin);
    deque_beat_t b;
    b.element  = elem;
    b.count    = COUNT_W'(ring_fill);
    b.is_empty = (ring_fill == 0);
    b.error    = err;
    b.last     = fin;
    beats_due.insert(beats_due.size(), b);
  endfunction

  // Apply one accepted request to the model and queue the beats it yields
  function automatic void predict_action(action_t act, logic signed [VALUE_W-1:0] v);
    int i, j, a, b;
    logic signed [VALUE_W-1:0] t;
    logic err;
    err = 1'b0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (ring_fill >= DEPTH) err = 1'b1;
        else begin
          ring_front = (ring_front + DEPTH - 1) % DEPTH;
          ring[ring_front] = v;
          ring_fill++;
        end
      end
      ACT_PUSH_BACK: begin
        if (ring_fill >= DEPTH) err = 1'b1;
        else begin
          ring[(ring_front + ring_fill) % DEPTH] = v;
          ring_fill++;
        end
      end
      ACT_POP_FRONT: begin
        if (ring_fill == 0) err = 1'b1;
        else begin
          ring_front = (ring_front + 1) % DEPTH;
          ring_fill--;
        end
      end
      ACT_POP_BACK: begin
        if (ring_fill == 0) err = 1'b1;
        else ring_fill--;
      end
      ACT_SORT: begin
        // exchange sort: each position against every later one
        for (i = 0; i + 1 < ring_fill; i++) begin
          for (j = i + 1; j < ring_fill; j++) begin
            a = (ring_front + i) % DEPTH;
            b = (ring_front + j) % DEPTH;
            if (ring[a] > ring[b]) begin
              t = ring[a];
              ring[a] = ring[b];
              ring[b] = t;
            end
          end
        end
      end
      ACT_CLEAR: begin
        ring_fill  = 0;
        ring_front = 0;
      end
      ACT_DUMP: begin
        if (ring_fill == 0) expect_beat('0, 1'b0, 1'b1);
        for (i = 0; i < ring_fill; i++)
          expect_beat(ring[(ring_front + i) % DEPTH], 1'b0, i + 1 == ring_fill);
        return;
      end
      default: ;
    endcase
    expect_beat('0, err, 1'b1);
  endfunction

  function automatic void queue_op(action_t a, logic signed [VALUE_W-1:0] v);
    deque_op_t op;
    op.act   = a;
    op.val   = v;
    op.pause = 1'b0;
    ops_pending.insert(ops_pending.size(), op);
  endfunction

  function automatic void queue_pause();
    deque_op_t op;
    op.act   = ACT_CLEAR;
    op.val   = '0;
    op.pause = 1'b1;
    ops_pending.insert(ops_pending.size(), op);
  endfunction

  // Extremes, small values for duplicates, or anything
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed(32'($urandom_range(0, 15))) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic void report_field(string name, logic signed [32:0] e,
                                       logic signed [32:0] g);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, g);
    n_fail++;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        predict_action(action_t'(req.action), req.value);
        ops_pending.delete(0);
        n_taken++;
      end
      if (!(req.valid && !req.ready)) begin
        // a pause marker clears once every outstanding beat has been taken
        if (ops_pending.size() > 0 && ops_pending[0].pause && beats_due.size() == 0)
          ops_pending.delete(0);
        if (ops_pending.size() > 0 && !ops_pending[0].pause && !idle_now()) begin
          req_valid  <= 1'b1;
          req_action <= ops_pending[0].act;
          req_value  <= ops_pending[0].val;
        end else begin
          req_valid  <= 1'b0;
          req_value  <= $urandom();
        end
      end
    end
  end

  // Result monitor and back-pressure
  always @(posedge clk) begin
    deque_beat_t exp_b;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual element %0d count %0d",
                   $time, rsp.element, rsp.count);
          n_fail++;
        end else begin
          exp_b = beats_due[0];
          beats_due.delete(0);
          if (rsp.element !== exp_b.element) report_field("element", exp_b.element, rsp.element);
          if (rsp.count !== exp_b.count) report_field("count", exp_b.count, rsp.count);
          if (rsp.is_empty !== exp_b.is_empty)
            report_field("is_empty", exp_b.is_empty, rsp.is_empty);
          if (rsp.error !== exp_b.error) report_field("error", exp_b.error, rsp.error);
          if (rsp.last !== exp_b.last) report_field("last", exp_b.last, rsp.last);
        end
      end
      rsp_ready <= !idle_now();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("sortable_deque_test NOT OK");
      $finish;
    end
  end

  initial begin
    int n_random, len, pick;
    n_random = 0;

    // Directed: empty cases, single element sort, extremes, wrap of the front pointer
    queue_op(ACT_DUMP, '0);
    queue_op(ACT_POP_FRONT, '0);
    queue_op(ACT_POP_BACK, '0);
    queue_op(ACT_SORT, '0);
    queue_op(ACT_PUSH_BACK, 32'sh8000_0000);
    queue_op(ACT_SORT, '0);
    queue_op(ACT_DUMP, '0);
    queue_op(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    queue_op(ACT_PUSH_BACK, 32'sh0);
    queue_op(ACT_PUSH_FRONT, -32'sh1);
    queue_op(ACT_PUSH_BACK, 32'sh1);
    queue_op(ACT_SORT, '0);
    queue_op(ACT_DUMP, '0);
    queue_op(ACT_POP_FRONT, '0);
    queue_op(ACT_POP_BACK, '0);
    queue_op(ACT_DUMP, '0);
    queue_op(ACT_CLEAR, '0);
    queue_op(ACT_DUMP, '0);
    queue_op(ACT_PUSH_FRONT, 32'sh5);
    queue_op(ACT_POP_BACK, '0);
    queue_op(ACT_POP_FRONT, '0);
    queue_pause();

    // Random: push and pop bursts, sort then dump, noise; first burst overfills
    while (n_random < N_RANDOM) begin
      pick = (n_random == 0) ? 0 : $urandom_range(0, 99);
      if (pick < 30) begin
        len = (n_random == 0) ? DEPTH + 4 : $urandom_range(1, DEPTH + 4);
        repeat (len) queue_op($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                              pick_value());
        n_random += len;
      end else if (pick < 52) begin
        len = $urandom_range(1, DEPTH + 4);
        repeat (len) queue_op($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT,
                              $urandom());
        n_random += len;
      end else if (pick < 66) begin
        queue_op(ACT_SORT, $urandom());
        queue_op(ACT_DUMP, $urandom());
        n_random += 2;
      end else if (pick < 82) begin
        len = $urandom_range(1, 6);
        repeat (len) queue_op(action_t'($urandom_range(0, 6)), pick_value());
        n_random += len;
      end else if (pick < 90) begin
        queue_op(ACT_DUMP, $urandom());
        n_random++;
      end else if (pick < 95) begin
        queue_op(ACT_CLEAR, $urandom());
        n_random++;
      end else begin
        queue_pause();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (ops_pending.size() != 0 || beats_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_fail == 0) $display("sortable_deque_test OK");
    else $display("sortable_deque_test NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sdq_pkg.sv
rtl/sdq_req_if.sv
rtl/sdq_rsp_if.sv
rtl/sdq_ram.sv
rtl/sdq_dp.sv
rtl/sdq_ctrl.sv
rtl/sortable_deque.sv
tb/sortable_deque_test.sv
